/* hdl/qwt_pkg.sv */
// Package for the quoted word tokenizer: result kinds, special byte codes,
// the result record and the lexer-to-queue push bundle.
// Depends on nothing.
package qwt_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  // bytes with a meaning to the lexer
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // most results one input byte can cause
  localparam int unsigned MaxResults = 3;

  // default depth of the result queue, at least MaxResults
  localparam int unsigned QwtFifoDepth = 4;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
  } res_t;

  // results of one transfer, slot 0 first
  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MaxResults-1:0] slot;
  } push_t;

endpackage

/* hdl/qwt_lexer.sv */
// Quoted word lexer: quoting and escape state plus the decode of one byte
// into up to three results. Depends on qwt_pkg.
module qwt_lexer
  import qwt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       line_end_i,
  output push_t      push_o
);

  logic sq_q, sq_d;
  logic dq_q, dq_d;
  logic esc_q, esc_d;
  logic delim_q, delim_d;
  logic start_q, start_d;

  logic  is_special;
  logic  normal;
  logic  [1:0] n;
  res_t  [MaxResults-1:0] slot;

  assign is_special = (in_char_i == CH_DQUOTE) || (in_char_i == CH_BACKSLASH) ||
                      (in_char_i == CH_DOLLAR) || (in_char_i == CH_BACKTICK);

  // decode of one byte against the current quoting state
  always_comb begin
    sq_d    = sq_q;
    dq_d    = dq_q;
    esc_d   = esc_q;
    delim_d = delim_q;
    start_d = start_q;
    normal  = 1'b1;
    n       = 2'd0;
    slot    = '0;

    // byte after a backslash
    if (esc_q) begin
      esc_d = 1'b0;
      if (dq_q && !is_special) begin
        slot[n] = '{kind: KIND_BYTE, ch: CH_BACKSLASH, last: 1'b0};
        n       = n + 2'd1;
      end else begin
        slot[n] = '{kind: KIND_BYTE, ch: in_char_i, last: 1'b0};
        n       = n + 2'd1;
        normal  = 1'b0;
      end
    end

    // ordinary handling
    if (normal) begin
      if (!sq_q && !dq_q && (in_char_i == CH_SPACE)) begin
        if (!start_q) begin
          delim_d = 1'b1;
        end
      end else begin
        if (delim_q) begin
          slot[n] = '{kind: KIND_END, ch: 8'h00, last: 1'b0};
          n       = n + 2'd1;
          delim_d = 1'b0;
        end
        start_d = 1'b0;
        if (in_char_i == CH_BACKSLASH) begin
          if (sq_q || line_end_i) begin
            slot[n] = '{kind: KIND_BYTE, ch: in_char_i, last: 1'b0};
            n       = n + 2'd1;
          end else begin
            esc_d = 1'b1;
          end
        end else if ((in_char_i == CH_SQUOTE) && !dq_q) begin
          sq_d = !sq_q;
        end else if ((in_char_i == CH_DQUOTE) && !sq_q) begin
          dq_d = !dq_q;
        end else begin
          slot[n] = '{kind: KIND_BYTE, ch: in_char_i, last: 1'b0};
          n       = n + 2'd1;
        end
      end
    end

    // line end closes the word or marks an empty line, then state resets
    if (line_end_i) begin
      slot[n] = '{kind: (start_d ? KIND_EMPTY : KIND_CLOSE), ch: 8'h00, last: 1'b0};
      n       = n + 2'd1;
      sq_d    = 1'b0;
      dq_d    = 1'b0;
      esc_d   = 1'b0;
      delim_d = 1'b0;
      start_d = 1'b1;
    end

    // flag the final result of this byte
    if (n != 2'd0) begin
      slot[n - 2'd1].last = 1'b1;
    end
  end

  assign push_o.cnt  = accept_i ? n : 2'd0;
  assign push_o.slot = slot;

  // state update on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q    <= 1'b0;
      dq_q    <= 1'b0;
      esc_q   <= 1'b0;
      delim_q <= 1'b0;
      start_q <= 1'b1;
    end else if (accept_i) begin
      sq_q    <= sq_d;
      dq_q    <= dq_d;
      esc_q   <= esc_d;
      delim_q <= delim_d;
      start_q <= start_d;
    end
  end

endmodule

/* hdl/qwt_res_fifo.sv */
// Result queue: takes up to three results a cycle, hands out one a cycle while popped.
// Depends on qwt_pkg.
module qwt_res_fifo
  import qwt_pkg::*;
#(
  parameter int unsigned Depth = QwtFifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  push_t                      push_i,
  input  logic                       pop_i,
  output logic                       room_o,
  output logic                       valid_o,
  output res_t                       head_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned SumW = PtrW + 2;

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] widx [MaxResults];
  logic [SumW-1:0] wsum [MaxResults];
  logic [SumW-1:0] rsum;

  // write addresses for each slot, wrapped
  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      wsum[i] = {2'b00, wr_q} + SumW'(i);
      if (wsum[i] >= SumW'(Depth)) begin
        wsum[i] = wsum[i] - SumW'(Depth);
      end
      widx[i] = wsum[i][PtrW-1:0];
    end
  end

  // pointer and fill level update
  always_comb begin
    rsum = {2'b00, rd_q} + SumW'(1);
    if (rsum >= SumW'(Depth)) begin
      rsum = rsum - SumW'(Depth);
    end
    rd_d = pop_i ? rsum[PtrW-1:0] : rd_q;
    wr_d = wr_q;
    unique case (push_i.cnt)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = widx[1];
      2'd2:    wr_d = widx[2];
      default: wr_d = (widx[2] == PtrW'(Depth - 1)) ? '0 : widx[2] + PtrW'(1);
    endcase
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[widx[i]] <= push_i.slot[i];
      end
    end
  end

  assign room_o  = (cnt_q <= CntW'(Depth - MaxResults));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;

endmodule

/* hdl/quoted_word_tokenizer.sv */
// Quoted word tokenizer, top level: lexer feeding a small result queue.
// Each result is stored in the result queue on its byte's transfer and offered from its head in order.
// Throughput: one byte per cycle while each byte gives at most one result
//   and out_stall_i is low; output drains one result per cycle, so extra results stall the input.
// The input stalls while the result queue cannot take three more results.
// Reset (asynchronous, active low): empty queue, unquoted, at line start.
module quoted_word_tokenizer
  import qwt_pkg::*;
#(
  parameter int unsigned FifoDepth = QwtFifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o
);

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic            accept;
  logic            pop;
  logic            room;
  push_t           push;
  res_t            head;
  logic [CntW-1:0] level;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  qwt_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_char_i  (in_char_i),
    .line_end_i (line_end_i),
    .push_o     (push)
  );

  qwt_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head),
    .level_o (level)
  );

  // output fields from the queue head
  assign kind_o        = head.kind;
  assign out_char_o    = head.ch;
  assign last_of_run_o = head.last;

  // queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  // a line-end byte always gives at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && line_end_i) |-> (push.cnt != 2'd0))
    else $error("line end produced no result");

  // pushes only happen on an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> (push.cnt == 2'd0))
    else $error("push without input transfer");

  // fill level follows pushes and pops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (level == $past(level) + CntW'($past(push.cnt)) - CntW'($past(pop))))
    else $error("fill level mismatch");

endmodule

/* dv/tb_quoted_word_tokenizer.sv */
// Testbench for quoted_word_tokenizer: directed and random command lines, a
// behavioral word splitter for expected results, randomized source/sink idling.
// Depends on qwt_pkg and the quoted_word_tokenizer RTL.
module tb_quoted_word_tokenizer
  import qwt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StuckLimit = 2000;

  typedef struct {
    logic [7:0] ch;
    logic       le;
  } line_byte_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_char_i   = 8'h00;
  logic       line_end_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_char_o;
  logic       last_of_run_o;

  line_byte_t  byte_queue[$];
  res_t        exp_results[$];
  res_t        want_res;
  int unsigned tx_idle_pct  = 27;
  int unsigned rx_idle_pct  = 56;
  int unsigned errors       = 0;
  int unsigned stuck_cycles = 0;

  // splitter state, mirrors the block after reset
  bit in_squote  = 1'b0;
  bit in_dquote  = 1'b0;
  bit esc_wait   = 1'b0;
  bit word_gap   = 1'b0;
  bit line_fresh = 1'b1;

  quoted_word_tokenizer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_char_i    (in_char_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_char_o   (out_char_o),
    .last_of_run_o(last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic res_t mk_res(kind_e k, logic [7:0] c);
    res_t r;
    r.kind = k;
    r.ch   = (k == KIND_BYTE) ? c : 8'h00;
    r.last = 1'b0;
    return r;
  endfunction

  // expected results of one byte transfer, state updated in place
  function automatic void tokenize_byte(input logic [7:0] c, input logic le);
    res_t run[$];
    bit   plain;
    bit   unquoted;
    plain = 1'b1;
    // byte following a backslash
    if (esc_wait) begin
      esc_wait = 1'b0;
      if (in_dquote) begin
        if (c == CH_DQUOTE || c == CH_BACKSLASH || c == CH_DOLLAR || c == CH_BACKTICK) begin
          run.push_back(mk_res(KIND_BYTE, c));
          plain = 1'b0;
        end else begin
          run.push_back(mk_res(KIND_BYTE, CH_BACKSLASH));
        end
      end else begin
        run.push_back(mk_res(KIND_BYTE, c));
        plain = 1'b0;
      end
    end
    if (plain) begin
      unquoted = !in_squote && !in_dquote;
      if (unquoted && c == CH_SPACE) begin
        if (!line_fresh) word_gap = 1'b1;
      end else begin
        // held-back word end is released by the next word
        if (word_gap) begin
          run.push_back(mk_res(KIND_END, 8'h00));
          word_gap = 1'b0;
        end
        line_fresh = 1'b0;
        if (c == CH_BACKSLASH) begin
          if (in_squote || le) run.push_back(mk_res(KIND_BYTE, c));
          else esc_wait = 1'b1;
        end else if (c == CH_SQUOTE && !in_dquote) begin
          in_squote = !in_squote;
        end else if (c == CH_DQUOTE && !in_squote) begin
          in_dquote = !in_dquote;
        end else begin
          run.push_back(mk_res(KIND_BYTE, c));
        end
      end
    end
    // line end closes the word or marks an empty line, and clears all state
    if (le) begin
      run.push_back(mk_res(line_fresh ? KIND_EMPTY : KIND_CLOSE, 8'h00));
      in_squote  = 1'b0;
      in_dquote  = 1'b0;
      esc_wait   = 1'b0;
      word_gap   = 1'b0;
      line_fresh = 1'b1;
    end
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
      foreach (run[i]) exp_results.push_back(run[i]);
    end
  endfunction

  task automatic add_byte(input logic [7:0] c, input logic le);
    line_byte_t b;
    b.ch = c;
    b.le = le;
    byte_queue.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endtask

  // byte mix weighted toward the characters the lexer cares about
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return CH_SPACE;
    if (r < 28) return CH_SQUOTE;
    if (r < 38) return CH_DQUOTE;
    if (r < 50) return CH_BACKSLASH;
    if (r < 54) return CH_DOLLAR;
    if (r < 58) return CH_BACKTICK;
    if (r < 85) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // mostly whole lines, some loose noise bytes
  task automatic fill_random(input int unsigned count);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(9) == 0) begin
        add_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        added++;
      end else begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) add_byte(pick_char(), i == len - 1);
        added += len;
      end
    end
  endtask

  // input driver, records each transfer with the splitter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_char_i  <= 8'h00;
      line_end_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) tokenize_byte(in_char_i, line_end_i);
      if (!in_valid_i || !in_stall_o) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_char_i  <= byte_queue[0].ch;
          line_end_i <= byte_queue[0].le;
          void'(byte_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor and sink stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (exp_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual kind %0d char %02h last %0b",
                   $time, kind_o, out_char_o, last_of_run_o);
        end else begin
          want_res = exp_results.pop_front();
          if (kind_o !== want_res.kind) begin
            errors++;
            $display("%0t: kind expected %0d actual %0d", $time, want_res.kind, kind_o);
          end
          if (out_char_o !== want_res.ch) begin
            errors++;
            $display("%0t: out_char expected %02h actual %02h", $time, want_res.ch, out_char_o);
          end
          if (last_of_run_o !== want_res.last) begin
            errors++;
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want_res.last, last_of_run_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog on cycles without any transfer while work is outstanding
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (byte_queue.size() == 0 && !in_valid_i && exp_results.size() == 0)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned tx_pct[3];
    int unsigned rx_pct[3];
    tx_pct = '{27, 56, 0};
    rx_pct = '{56, 27, 0};

    // directed lines
    add_text(" ");           // blank line
    add_text("  a b");       // leading spaces, word end plus byte plus close
    add_text("c  ");         // trailing spaces trimmed
    add_text("''");          // empty quoted word
    add_text("a\\ b");       // escaped space inside a word
    add_text("\"\\$\\q\"");  // double-quote escape and kept backslash
    add_text("'\\");         // backslash in single quotes, unclosed at line end
    add_text("\" \"");       // quoted space is word content
    add_byte(8'h00, 1'b0);   // zero byte is literal
    add_byte(8'hFF, 1'b1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_idle_pct = rx_pct[p];
      fill_random(117);
      // hold off until everything sent has come back
      while (!(byte_queue.size() == 0 && !in_valid_i && exp_results.size() == 0))
        @(posedge clk_i);
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
